[sv/vma_pkg.sv]
`default_nettype none

package vma_pkg;

  localparam int FIELD_COUNT = 8;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W = 8;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd100;
  localparam int LANES_DEFAULT = 8;
  localparam int WINDOW_DEPTH_DEFAULT = 128;
  localparam int LEN_LIMIT = 255;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
    logic signed [SAMPLE_W-1:0] sample_4;
    logic signed [SAMPLE_W-1:0] sample_5;
    logic signed [SAMPLE_W-1:0] sample_6;
    logic signed [SAMPLE_W-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average_0;
    logic signed [SAMPLE_W-1:0] average_1;
    logic signed [SAMPLE_W-1:0] average_2;
    logic signed [SAMPLE_W-1:0] average_3;
    logic signed [SAMPLE_W-1:0] average_4;
    logic signed [SAMPLE_W-1:0] average_5;
    logic signed [SAMPLE_W-1:0] average_6;
    logic signed [SAMPLE_W-1:0] average_7;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_DONE
  } vma_state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic load;
    logic step;
    logic finish;
  } vma_cmd_t;

  typedef struct packed {
    logic out_busy;
  } vma_sts_t;

  function automatic int calc_max_len(int depth);
    return (depth < LEN_LIMIT) ? depth : LEN_LIMIT;
  endfunction

  function automatic int calc_cnt_w(int depth);
    return $clog2(calc_max_len(depth) + 1);
  endfunction

  function automatic int calc_div_iter(int depth);
    return (SAMPLE_W + calc_cnt_w(depth) + 1) >> 1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] get_sample(in_item_t item, int idx);
    logic signed [SAMPLE_W-1:0] s;
    unique case (idx)
      0: s = item.sample_0;
      1: s = item.sample_1;
      2: s = item.sample_2;
      3: s = item.sample_3;
      4: s = item.sample_4;
      5: s = item.sample_5;
      6: s = item.sample_6;
      7: s = item.sample_7;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/vma_ram.sv]
`default_nettype none

module vma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire                                       clk_i,
  input  wire                                       we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                          wdata_i,
  input  wire                                       re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/vma_ctrl.sv]
`default_nettype none

module vma_ctrl
  import vma_pkg::*;
#(
  parameter int DIV_ITER = 12
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  vma_sts_t  sts_i,
  output vma_cmd_t  cmd_o
);

  localparam int IT_W = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(DIV_ITER - 1);

  vma_state_e state_q, state_d;
  logic [IT_W-1:0] iter_q, iter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        iter_d     = '0;
        state_d    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        iter_d     = iter_q + 1'b1;
        if (iter_q == IT_LAST) begin
          iter_d  = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && iter_q == IT_LAST) |=> state_q == ST_DONE)
    else $error("divide did not end after the last step");

endmodule

`default_nettype wire

[sv/vma_datapath.sv]
`default_nettype none

module vma_datapath
  import vma_pkg::*;
#(
  parameter int LANES = LANES_DEFAULT,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  vma_cmd_t         cmd_i,
  output vma_sts_t         sts_o,
  input  in_item_t         in_data_i,
  input  wire              cfg_valid_i,
  input  wire  [CFG_W-1:0] cfg_data_i,
  input  wire              out_ready_i,
  output logic             out_valid_o,
  output out_item_t        out_data_o
);

  localparam int MAX_LEN = calc_max_len(WINDOW_DEPTH);
  localparam int CNT_W = calc_cnt_w(WINDOW_DEPTH);
  localparam int SLOT_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int DIV_ITER = calc_div_iter(WINDOW_DEPTH);
  localparam int Q_W = 2 * DIV_ITER;
  localparam int ROW_W = LANES * SAMPLE_W;

  logic [CFG_W-1:0] window_q;
  logic [CNT_W-1:0] fill_q, len, fill_eff, slot_eff;
  logic [SLOT_W-1:0] slot_q, slot_cur_q;
  logic full_q;
  logic [CNT_W-1:0] div_q;
  logic out_valid_q;

  logic signed [SAMPLE_W-1:0] samp_q [LANES];
  logic signed [SUM_W-1:0]    sum_q  [LANES];
  logic [Q_W-1:0]             quo_q  [LANES];
  logic [CNT_W-1:0]           rem_q  [LANES];
  logic                       neg_q  [LANES];
  logic signed [SAMPLE_W-1:0] avg_q  [LANES];

  logic signed [SAMPLE_W-1:0] in_lane  [LANES];
  logic signed [SUM_W-1:0]    sum_upd  [LANES];
  logic [SUM_W-1:0]           mag      [LANES];
  logic [Q_W-1:0]             quo_next [LANES];
  logic [CNT_W-1:0]           rem_next [LANES];
  logic signed [SAMPLE_W-1:0] avg_next [LANES];
  logic signed [SAMPLE_W-1:0] avg_full [FIELD_COUNT];

  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0] slot_inc;

  always_comb begin
    if (window_q == '0) begin
      len = CNT_W'(1);
    end else if (window_q > CFG_W'(MAX_LEN)) begin
      len = CNT_W'(MAX_LEN);
    end else begin
      len = CNT_W'(window_q);
    end
    fill_eff = (fill_q > len) ? len : fill_q;
    slot_eff = (CNT_W'(slot_q) >= len) ? '0 : CNT_W'(slot_q);
    slot_inc = CNT_W'(slot_cur_q) + 1'b1;
  end

  vma_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (slot_cur_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (slot_eff[SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [CNT_W:0] t1, t2, r1, r2;
    logic ge1, ge2;
    logic signed [SAMPLE_W-1:0] old;

    assign in_lane[l] = get_sample(in_data_i, l);
    assign ram_wdata[l*SAMPLE_W +: SAMPLE_W] = samp_q[l];
    assign old = ram_rdata[l*SAMPLE_W +: SAMPLE_W];

    always_comb begin
      sum_upd[l] = sum_q[l] + SUM_W'(samp_q[l]);
      if (full_q) begin
        sum_upd[l] = sum_upd[l] - SUM_W'(old);
      end
      mag[l] = sum_q[l][SUM_W-1] ? SUM_W'(-sum_q[l]) : SUM_W'(sum_q[l]);

      t1  = {rem_q[l], quo_q[l][Q_W-1]};
      ge1 = (t1 >= {1'b0, div_q});
      r1  = ge1 ? (t1 - {1'b0, div_q}) : t1;
      t2  = {r1[CNT_W-1:0], quo_q[l][Q_W-2]};
      ge2 = (t2 >= {1'b0, div_q});
      r2  = ge2 ? (t2 - {1'b0, div_q}) : t2;
      rem_next[l] = r2[CNT_W-1:0];
      quo_next[l] = {quo_q[l][Q_W-3:0], ge1, ge2};

      avg_next[l] = neg_q[l] ? -quo_q[l][SAMPLE_W-1:0] : quo_q[l][SAMPLE_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q[l] <= '0;
      end else if (cfg_valid_i) begin
        sum_q[l] <= '0;
      end else if (cmd_i.update) begin
        sum_q[l] <= sum_upd[l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        samp_q[l] <= in_lane[l];
      end
      if (cmd_i.load) begin
        neg_q[l] <= sum_q[l][SUM_W-1];
        quo_q[l] <= Q_W'(mag[l]);
        rem_q[l] <= '0;
      end else if (cmd_i.step) begin
        quo_q[l] <= quo_next[l];
        rem_q[l] <= rem_next[l];
      end
      if (cmd_i.finish) begin
        avg_q[l] <= avg_next[l];
      end
    end
  end

  for (genvar f = 0; f < FIELD_COUNT; f++) begin : g_field
    if (f < LANES) begin : g_used
      assign avg_full[f] = avg_q[f];
    end else begin : g_unused
      assign avg_full[f] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      fill_q   <= '0;
      slot_q   <= '0;
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
      fill_q   <= '0;
      slot_q   <= '0;
    end else if (cmd_i.update) begin
      fill_q <= full_q ? fill_eff : fill_eff + 1'b1;
      slot_q <= (slot_inc >= len) ? '0 : slot_inc[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      slot_cur_q <= slot_eff[SLOT_W-1:0];
      full_q     <= (fill_eff == len);
    end
    if (cmd_i.load) begin
      div_q <= fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = '{
    average_0: avg_full[0], average_1: avg_full[1],
    average_2: avg_full[2], average_3: avg_full[3],
    average_4: avg_full[4], average_5: avg_full[5],
    average_6: avg_full[6], average_7: avg_full[7]
  };

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= len)
    else $error("fill count exceeds the window length");

  assert property (@(posedge clk_i) disable iff (!rst_ni) CNT_W'(slot_q) < len)
    else $error("write slot outside the window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[sv/vector_moving_average.sv]
// Channel   Direction  Handshake                     Payload
// in        input      in_valid_i / in_ready_o       in_data_i  (in_item_t)
// out       output     out_valid_o / out_ready_i     out_data_o (out_item_t)
// cfg       input      cfg_valid_i / cfg_ready_o     cfg_data_i (window length)
//
// A request passes the update, load, divide and done states between acceptance and the
// next one; the divide state runs the two-bit-per-cycle restoring divider in each lane.
// The result waits in an output register, so a new request is taken while it is unread.
// Reset clears the sums, fill count and write slot and sets the window length to 100.
// The sample ring is not cleared, since a slot is only read after it was written.
`default_nettype none

module vector_moving_average
  import vma_pkg::*;
#(
  parameter int LANES = LANES_DEFAULT,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output out_item_t        out_data_o,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire  [CFG_W-1:0] cfg_data_i
);

  vma_cmd_t cmd;
  vma_sts_t sts;

  assign cfg_ready_o = 1'b1;

  vma_ctrl #(
    .DIV_ITER (calc_div_iter(WINDOW_DEPTH))
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vma_datapath #(
    .LANES        (LANES),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
